@@ sv/hcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_pkg: shared types and constants for the hotkey chord detector
// Field widths, register map, item and result words, key value codes.
// ----------------------------------------------------------------------------
package hcd_pkg;

    // Default depth of the held-key store
    localparam int DEF_MAX_HELD = 16;

    // Chord shape: groups that are checked and alternatives per group
    localparam int MAX_GROUPS       = 4;
    localparam int MAX_ALTERNATIVES = 4;

    // Register layout of one requirement group
    localparam int REG_GROUPS     = 4;
    localparam int ALTS_PER_REG   = 4;
    localparam int CODE_W         = 10;
    localparam int REQ_EN_LSB     = ALTS_PER_REG * CODE_W;
    localparam int REQ_W          = REQ_EN_LSB + ALTS_PER_REG;

    localparam int LIVE_GROUPS = (MAX_GROUPS < REG_GROUPS) ? MAX_GROUPS : REG_GROUPS;
    localparam int LIVE_ALTS   =
        (MAX_ALTERNATIVES < ALTS_PER_REG) ? MAX_ALTERNATIVES : ALTS_PER_REG;

    // Field widths
    localparam int TYPE_W     = 5;
    localparam int VALUE_W    = 2;
    localparam int REQ_CNT_W  = 3;
    localparam int HELD_CNT_W = 5;
    localparam logic [HELD_CNT_W-1:0] HELD_CNT_MAX = '1;

    // Codes
    localparam logic [TYPE_W-1:0]  KEY_EVENT_TYPE = 5'd1;
    localparam logic [VALUE_W-1:0] KV_RELEASE     = 2'd0;
    localparam logic [VALUE_W-1:0] KV_PRESS       = 2'd1;
    localparam logic               KIND_DEV_ERROR = 1'b1;

    // APB register map (64-bit data, registers at 8*i)
    localparam int APB_DATA_W = 64;
    localparam int PADDR_W    = 6;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_KEYBIND_VALID = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REQ_COUNT     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REQ_0         = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REQ_1         = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REQ_2         = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REQ_3         = 3'd5;

    typedef logic [CODE_W-1:0] code_t;

    typedef struct packed {
        logic                              keybind_valid;
        logic [REQ_CNT_W-1:0]              req_count;
        logic [REG_GROUPS-1:0][REQ_W-1:0]  req;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [TYPE_W-1:0]  ev_type;
        code_t              ev_code;
        logic [VALUE_W-1:0] key_value;
    } item_t;

    typedef struct packed {
        logic                  chord_detected;
        logic [HELD_CNT_W-1:0] held_count;
        logic                  press_dropped;
    } res_t;

endpackage
`default_nettype wire

@@ sv/hcd_key_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_key_if: keyboard event channel
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
interface hcd_key_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [hcd_pkg::TYPE_W-1:0]  ev_type;
    hcd_pkg::code_t              ev_code;
    logic [hcd_pkg::VALUE_W-1:0] key_value;

    modport source (output valid, kind, ev_type, ev_code, key_value, input ready);
    modport sink   (input valid, kind, ev_type, ev_code, key_value, output ready);
endinterface
`default_nettype wire

@@ sv/hcd_res_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_res_if: detection result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface hcd_res_if;
    logic                           valid;
    logic                           ready;
    logic                           chord_detected;
    logic [hcd_pkg::HELD_CNT_W-1:0] held_count;
    logic                           press_dropped;

    modport source (output valid, chord_detected, held_count, press_dropped, input ready);
    modport sink   (input valid, chord_detected, held_count, press_dropped, output ready);
endinterface
`default_nettype wire

@@ sv/hcd_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_cfg_regs: APB configuration registers
// Keybind valid, group count and four requirement group registers.
// ----------------------------------------------------------------------------
module hcd_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [hcd_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [hcd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [hcd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    output hcd_pkg::cfg_t                           cfg
);

    hcd_pkg::cfg_t                    cfg_reg;
    logic [hcd_pkg::REG_IDX_W-1:0]    idx;
    logic                             wr;

    assign idx    = paddr[hcd_pkg::PADDR_W-1 -: hcd_pkg::REG_IDX_W];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            case (idx)
                hcd_pkg::REG_KEYBIND_VALID: cfg_reg.keybind_valid <= pwdata[0];
                hcd_pkg::REG_REQ_COUNT:
                    cfg_reg.req_count <= pwdata[hcd_pkg::REQ_CNT_W-1:0];
                hcd_pkg::REG_REQ_0: cfg_reg.req[0] <= pwdata[hcd_pkg::REQ_W-1:0];
                hcd_pkg::REG_REQ_1: cfg_reg.req[1] <= pwdata[hcd_pkg::REQ_W-1:0];
                hcd_pkg::REG_REQ_2: cfg_reg.req[2] <= pwdata[hcd_pkg::REQ_W-1:0];
                hcd_pkg::REG_REQ_3: cfg_reg.req[3] <= pwdata[hcd_pkg::REQ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            hcd_pkg::REG_KEYBIND_VALID:
                prdata = hcd_pkg::APB_DATA_W'(cfg_reg.keybind_valid);
            hcd_pkg::REG_REQ_COUNT: prdata = hcd_pkg::APB_DATA_W'(cfg_reg.req_count);
            hcd_pkg::REG_REQ_0:     prdata = hcd_pkg::APB_DATA_W'(cfg_reg.req[0]);
            hcd_pkg::REG_REQ_1:     prdata = hcd_pkg::APB_DATA_W'(cfg_reg.req[1]);
            hcd_pkg::REG_REQ_2:     prdata = hcd_pkg::APB_DATA_W'(cfg_reg.req[2]);
            hcd_pkg::REG_REQ_3:     prdata = hcd_pkg::APB_DATA_W'(cfg_reg.req[3]);
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/hcd_chord_match.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_chord_match: parallel chord compare
// Checks every enabled alternative of every group against the held set,
// including a code being added this cycle.
// ----------------------------------------------------------------------------
module hcd_chord_match #(
    parameter int MAX_HELD = hcd_pkg::DEF_MAX_HELD
) (
    input  wire hcd_pkg::cfg_t    cfg,
    input  wire hcd_pkg::code_t   held_codes [MAX_HELD],
    input  wire logic [MAX_HELD-1:0] held_valid,
    input  wire logic             add,
    input  wire hcd_pkg::code_t   add_code,
    output logic                  chord_match
);

    logic [hcd_pkg::MAX_GROUPS-1:0] grp_ok;
    logic [hcd_pkg::MAX_GROUPS-1:0] grp_need;

    always_comb
    begin
        hcd_pkg::code_t alt_code;
        logic           alt_hit;
        grp_ok = '0;
        for (int g = 0; g < hcd_pkg::LIVE_GROUPS; g++)
        begin
            for (int a = 0; a < hcd_pkg::LIVE_ALTS; a++)
            begin
                alt_code = cfg.req[g][a*hcd_pkg::CODE_W +: hcd_pkg::CODE_W];
                alt_hit  = add && (add_code == alt_code);
                for (int i = 0; i < MAX_HELD; i++)
                begin
                    alt_hit = alt_hit || (held_valid[i] && (held_codes[i] == alt_code));
                end
                if (cfg.req[g][hcd_pkg::REQ_EN_LSB + a] && alt_hit)
                begin
                    grp_ok[g] = 1'b1;
                end
            end
        end
    end

    // group g is required while g < requirement_count (saturation is implied)
    always_comb
    begin
        for (int g = 0; g < hcd_pkg::MAX_GROUPS; g++)
        begin
            grp_need[g] = cfg.req_count > hcd_pkg::REQ_CNT_W'(g);
        end
    end

    assign chord_match = cfg.keybind_valid && (&(~grp_need | grp_ok));

endmodule
`default_nettype wire

@@ sv/hcd_held_set.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hcd_held_set: held-key store and armed flag
// Applies one event word per strobe and forms its result word.
// ----------------------------------------------------------------------------
module hcd_held_set #(
    parameter int MAX_HELD = hcd_pkg::DEF_MAX_HELD
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  wire hcd_pkg::item_t item,
    input  wire hcd_pkg::cfg_t  cfg,
    output hcd_pkg::res_t       res
);

    localparam int CNT_W = $clog2(MAX_HELD + 1);
    localparam int SUM_W = (CNT_W > hcd_pkg::HELD_CNT_W) ? CNT_W : hcd_pkg::HELD_CNT_W;

    hcd_pkg::code_t      held_codes_reg [MAX_HELD];
    logic [MAX_HELD-1:0] held_valid_reg;
    logic [MAX_HELD-1:0] held_valid_next;
    logic                armed_reg;
    logic                armed_next;

    logic [MAX_HELD-1:0] hit;
    logic [MAX_HELD-1:0] free;
    logic [MAX_HELD-1:0] first_free;
    logic                is_key;
    logic                is_release;
    logic                is_press;
    logic                add;
    logic                dropped;
    logic                chord_match;
    logic                detected;
    logic [SUM_W-1:0]    cnt;

    always_comb
    begin
        for (int i = 0; i < MAX_HELD; i++)
        begin
            hit[i] = held_valid_reg[i] && (held_codes_reg[i] == item.ev_code);
        end
    end

    assign free       = ~held_valid_reg;
    assign first_free = free & (~free + MAX_HELD'(1));

    assign is_key     = (item.kind != hcd_pkg::KIND_DEV_ERROR)
                     && (item.ev_type == hcd_pkg::KEY_EVENT_TYPE);
    assign is_release = is_key && (item.key_value == hcd_pkg::KV_RELEASE);
    assign is_press   = is_key && (item.key_value == hcd_pkg::KV_PRESS);
    assign add        = is_press && !(|hit) && (|free);
    assign dropped    = is_press && !(|hit) && !(|free);

    hcd_chord_match #(
        .MAX_HELD (MAX_HELD)
    ) u_match (
        .cfg         (cfg),
        .held_codes  (held_codes_reg),
        .held_valid  (held_valid_reg),
        .add         (add),
        .add_code    (item.ev_code),
        .chord_match (chord_match)
    );

    // autorepeat and the unused value three both check the chord
    assign detected = is_key && !is_release && armed_reg && chord_match;

    always_comb
    begin
        if (item.kind == hcd_pkg::KIND_DEV_ERROR)
        begin
            held_valid_next = '0;
            armed_next      = 1'b1;
        end
        else if (is_release)
        begin
            held_valid_next = held_valid_reg & ~hit;
            armed_next      = 1'b1;
        end
        else
        begin
            held_valid_next = add ? (held_valid_reg | first_free) : held_valid_reg;
            armed_next      = armed_reg && !detected;
        end
    end

    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < MAX_HELD; i++)
        begin
            cnt = cnt + SUM_W'(held_valid_next[i]);
        end
    end

    assign res.chord_detected = detected;
    assign res.press_dropped  = dropped;
    assign res.held_count     = (cnt > SUM_W'(hcd_pkg::HELD_CNT_MAX))
                              ? hcd_pkg::HELD_CNT_MAX
                              : cnt[hcd_pkg::HELD_CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= '0;
            armed_reg      <= 1'b1;
        end
        else if (go)
        begin
            held_valid_reg <= held_valid_next;
            armed_reg      <= armed_next;
        end
    end

    // code store: no reset, an entry is only read while its valid bit is set
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_HELD; i++)
        begin
            if (go && add && first_free[i])
            begin
                held_codes_reg[i] <= item.ev_code;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/hotkey_chord_detector.sv @@
`default_nettype none
// Word accept to result valid passes the input register, then the result register.
// Throughput: one word per cycle while result.ready keeps up; held-set update and
//   chord compare are combinational, so each word sees the state left by the last.
// Reset (rst_n, async, active low): held set empty, armed, valid and config zero; no
//   clearing pass, the block accepts words as soon as reset is released.
// ----------------------------------------------------------------------------
// hotkey_chord_detector: keyboard chord detector top level
// Input register, held-set compute stage, result register, APB registers.
// ----------------------------------------------------------------------------
module hotkey_chord_detector #(
    parameter int MAX_HELD = hcd_pkg::DEF_MAX_HELD
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    hcd_key_if.sink                             keys,
    hcd_res_if.source                           result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hcd_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [hcd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [hcd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    hcd_pkg::cfg_t  cfg;
    hcd_pkg::item_t item_reg;
    hcd_pkg::res_t  res;
    hcd_pkg::res_t  res_reg;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic           advance;
    logic           go;

    // ---------------- configuration ----------------
    hcd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- handshake ----------------
    // Result register frees up when empty or being taken; the input register
    // moves into compute whenever the result register can take the outcome.
    assign advance    = !out_valid_reg || result.ready;
    assign go         = in_valid_reg && advance;
    assign keys.ready = !in_valid_reg || advance;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (keys.ready)
        begin
            in_valid_reg <= keys.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keys.ready && keys.valid)
        begin
            item_reg.kind      <= keys.kind;
            item_reg.ev_type   <= keys.ev_type;
            item_reg.ev_code   <= keys.ev_code;
            item_reg.key_value <= keys.key_value;
        end
    end

    // ---------------- held set, armed flag, chord compare ----------------
    hcd_held_set #(
        .MAX_HELD (MAX_HELD)
    ) u_held (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_reg <= res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.chord_detected = res_reg.chord_detected;
    assign result.held_count     = res_reg.held_count;
    assign result.press_dropped  = res_reg.press_dropped;

endmodule
`default_nettype wire

@@ dv/hcd_chord_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcd_chord_checker: scoreboard for the hotkey chord detector
// Watches the event, result and APB channels, keeps its own held-key set,
// armed flag and chord registers, and checks every result word in order.
// ----------------------------------------------------------------------------
module hcd_chord_checker #(
    parameter int HELD_DEPTH = hcd_pkg::DEF_MAX_HELD
) (
    input  logic                           clk,
    input  logic                           rst_n,
    hcd_key_if                             keys,
    hcd_res_if                             result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [hcd_pkg::PADDR_W-1:0]    paddr,
    input  logic [hcd_pkg::APB_DATA_W-1:0] pwdata,
    output int                             fail_count,
    output int                             pending
);
    import hcd_pkg::*;

    // chord registers as last written
    logic                 chord_loaded;
    logic [REQ_CNT_W-1:0] group_count;
    logic [REQ_W-1:0]     group_reg [REG_GROUPS];

    // held-key set and armed flag
    code_t                held_key [HELD_DEPTH];
    logic [HELD_DEPTH-1:0] held_on;
    logic                 armed;

    res_t expected_reports [$];
    int   mismatches = 0;

    function automatic logic key_is_held(code_t c);
        for (int i = 0; i < HELD_DEPTH; i++)
        begin
            if (held_on[i] && held_key[i] == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic chord_present();
        int   n;
        logic hit;
        if (!chord_loaded)
            return 1'b0;
        n = (int'(group_count) > MAX_GROUPS) ? MAX_GROUPS : int'(group_count);
        for (int g = 0; g < n; g++)
        begin
            if (g >= REG_GROUPS)
                return 1'b0;
            hit = 1'b0;
            for (int a = 0; a < MAX_ALTERNATIVES && a < ALTS_PER_REG; a++)
            begin
                if (group_reg[g][REQ_EN_LSB + a]
                    && key_is_held(group_reg[g][a*CODE_W +: CODE_W]))
                    hit = 1'b1;
            end
            if (!hit)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one event word to the held set and returns the result word it yields.
    function automatic res_t next_report(item_t w);
        res_t r;
        int   slot;
        int   n;
        r = '0;
        if (w.kind == KIND_DEV_ERROR)
        begin
            held_on = '0;
            armed   = 1'b1;
        end
        else if (w.ev_type == KEY_EVENT_TYPE)
        begin
            if (w.key_value == KV_RELEASE)
            begin
                for (int i = 0; i < HELD_DEPTH; i++)
                begin
                    if (held_on[i] && held_key[i] == w.ev_code)
                        held_on[i] = 1'b0;
                end
                armed = 1'b1;
            end
            else
            begin
                if (w.key_value == KV_PRESS && !key_is_held(w.ev_code))
                begin
                    slot = -1;
                    for (int i = HELD_DEPTH - 1; i >= 0; i--)
                    begin
                        if (!held_on[i])
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        held_key[slot] = w.ev_code;
                        held_on[slot]  = 1'b1;
                    end
                    else
                    begin
                        r.press_dropped = 1'b1;
                    end
                end
                if (armed && chord_present())
                begin
                    armed            = 1'b0;
                    r.chord_detected = 1'b1;
                end
            end
        end
        n = $countones(held_on);
        r.held_count = (n > int'(HELD_CNT_MAX)) ? HELD_CNT_MAX : HELD_CNT_W'(n);
        return r;
    endfunction

    always @(posedge clk)
    begin
        res_t  got;
        res_t  want;
        res_t  fresh;
        item_t w;
        if (!rst_n)
        begin
            chord_loaded = 1'b0;
            group_count  = '0;
            for (int g = 0; g < REG_GROUPS; g++)
                group_reg[g] = '0;
            held_on = '0;
            armed   = 1'b1;
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            // result side first: it belongs to an older word than any accepted now
            if (result.valid && result.ready)
            begin
                got = {result.chord_detected, result.held_count, result.press_dropped};
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: det=%0d held=%0d drop=%0d",
                                 $realtime, got.chord_detected, got.held_count,
                                 got.press_dropped);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: mismatch: expected det=%0d held=%0d drop=%0d",
                                     $realtime, want.chord_detected, want.held_count,
                                     want.press_dropped);
                            $display("%0t: mismatch: actual   det=%0d held=%0d drop=%0d",
                                     $realtime, got.chord_detected, got.held_count,
                                     got.press_dropped);
                        end
                    end
                end
            end
            if (keys.valid && keys.ready)
            begin
                w = {keys.kind, keys.ev_type, keys.ev_code, keys.key_value};
                fresh = next_report(w);
                expected_reports = {expected_reports, fresh};
            end
            if (psel && penable && pwrite && pready)
            begin
                case (REG_IDX_W'(paddr >> 3))
                    REG_KEYBIND_VALID: chord_loaded = pwdata[0];
                    REG_REQ_COUNT:     group_count  = pwdata[REQ_CNT_W-1:0];
                    REG_REQ_0:         group_reg[0] = pwdata[REQ_W-1:0];
                    REG_REQ_1:         group_reg[1] = pwdata[REQ_W-1:0];
                    REG_REQ_2:         group_reg[2] = pwdata[REQ_W-1:0];
                    REG_REQ_3:         group_reg[3] = pwdata[REQ_W-1:0];
                    default: ;
                endcase
            end
            pending <= expected_reports.size();
        end
        fail_count <= mismatches;
    end

endmodule

@@ dv/tb_hotkey_chord_detector.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hotkey_chord_detector: testbench for the hotkey chord detector
// Directed words for the corner cases, then random phases under varied chord
// settings with bursty events and a stalling result sink; a side checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_hotkey_chord_detector;
    import hcd_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int RANDOM_WORDS  = 1100;
    localparam int PHASES        = 6;
    localparam int DRAIN_CYCLES  = 4;     // slack after the last result word
    localparam int POOL_SIZE     = 6;

    // event codes not in the package
    localparam logic               KIND_EVENT = 1'b0;
    localparam logic [TYPE_W-1:0]  EV_SYNC    = 5'd0;
    localparam logic [TYPE_W-1:0]  EV_TOP     = 5'd31;
    localparam logic [VALUE_W-1:0] KV_REPEAT  = 2'd2;
    localparam logic [VALUE_W-1:0] KV_ODD     = 2'd3;

    // burst flavors of the random part
    localparam int STYLE_CHORD = 0;   // chord keys, balanced press/release
    localparam int STYLE_FILL  = 1;   // mostly fresh presses, drives the set full
    localparam int STYLE_NOISE = 2;   // non-key types and device errors

    localparam logic [REQ_W-1:0] REQ_ALL_ONES = '1;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic sink_ready = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    code_t chord_pool [POOL_SIZE];

    hcd_key_if keys_ch ();
    hcd_res_if res_ch ();

    assign res_ch.ready = sink_ready;

    hotkey_chord_detector u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .keys    (keys_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hcd_chord_checker #(
        .HELD_DEPTH (DEF_MAX_HELD)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .keys       (keys_ch),
        .result     (res_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Watchdog: far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("tb_hotkey_chord_detector NOT OK");
            $finish;
        end
    end

    // Result sink: switches among four stall patterns, including stretches of
    // steady ready.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_beat = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end
        else
        begin
            stall_left--;
        end
        stall_beat++;
        if (!rst_n)
            sink_ready <= 1'b0;
        else
        begin
            case (stall_mode)
                0: sink_ready <= 1'b1;
                1: sink_ready <= ($urandom_range(0, 3) != 0);
                2: sink_ready <= ($urandom_range(0, 3) == 0);
                default: sink_ready <= ((stall_beat % 5) != 0);
            endcase
        end
    end

    // One event word; returns at the edge where it is taken.
    task automatic send_word(item_t w);
        keys_ch.valid     <= 1'b1;
        keys_ch.kind      <= w.kind;
        keys_ch.ev_type   <= w.ev_type;
        keys_ch.ev_code   <= w.ev_code;
        keys_ch.key_value <= w.key_value;
        @(posedge clk);
        while (!keys_ch.ready)
            @(posedge clk);
    endtask

    // Hold off input until every result word is back, then let the pipe settle.
    // The first edge lets the checker count the word taken just before.
    task automatic drain();
        keys_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB setup + access; psel stays up so writes can go back to back
    task automatic put_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic load_chord(logic kb, logic [REQ_CNT_W-1:0] cnt, logic [REQ_W-1:0] r0,
                              logic [REQ_W-1:0] r1, logic [REQ_W-1:0] r2,
                              logic [REQ_W-1:0] r3);
        put_reg(REG_KEYBIND_VALID, APB_DATA_W'(kb));
        put_reg(REG_REQ_COUNT,     APB_DATA_W'(cnt));
        put_reg(REG_REQ_0,         APB_DATA_W'(r0));
        put_reg(REG_REQ_1,         APB_DATA_W'(r1));
        put_reg(REG_REQ_2,         APB_DATA_W'(r2));
        put_reg(REG_REQ_3,         APB_DATA_W'(r3));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // group register: enables on top, alternative 0 in the low bits
    function automatic logic [REQ_W-1:0] pack_group(code_t c0, code_t c1, code_t c2,
                                                    code_t c3, logic [ALTS_PER_REG-1:0] en);
        return {en, c3, c2, c1, c0};
    endfunction

    function automatic item_t key_word(logic k, logic [TYPE_W-1:0] et, code_t c,
                                       logic [VALUE_W-1:0] v);
        item_t w;
        w.kind      = k;
        w.ev_type   = et;
        w.ev_code   = c;
        w.key_value = v;
        return w;
    endfunction

    function automatic logic [REQ_W-1:0] random_group();
        code_t                   c [ALTS_PER_REG];
        logic [ALTS_PER_REG-1:0] en;
        for (int a = 0; a < ALTS_PER_REG; a++)
        begin
            // now and then a random code from the whole code space: above 767 never held, never matches
            if ($urandom_range(0, 9) == 0)
                c[a] = code_t'($urandom_range(0, 1023));
            else
                c[a] = chord_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        en = ($urandom_range(0, 7) == 0) ? '0 : ALTS_PER_REG'($urandom_range(1, 15));
        return pack_group(c[0], c[1], c[2], c[3], en);
    endfunction

    function automatic item_t make_word(int style);
        item_t w;
        int    roll;
        w.kind    = KIND_EVENT;
        w.ev_type = KEY_EVENT_TYPE;
        w.ev_code = code_t'($urandom_range(0, 767));
        roll      = $urandom_range(0, 99);
        case (style)
            STYLE_NOISE:
            begin
                w.kind      = ($urandom_range(0, 4) == 0);
                w.ev_type   = TYPE_W'($urandom_range(0, 31));
                w.key_value = VALUE_W'($urandom_range(0, 3));
            end
            STYLE_FILL:
            begin
                w.kind = ($urandom_range(0, 99) == 0);
                if (roll < 8)
                    w.key_value = KV_RELEASE;
                else if (roll < 85)
                    w.key_value = KV_PRESS;
                else
                    w.key_value = KV_REPEAT;
            end
            default:
            begin
                w.kind = ($urandom_range(0, 49) == 0);
                if ($urandom_range(0, 19) == 0)
                    w.ev_type = TYPE_W'($urandom_range(0, 31));
                if ($urandom_range(0, 9) < 7)
                    w.ev_code = chord_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (roll < 38)
                    w.key_value = KV_RELEASE;
                else if (roll < 80)
                    w.key_value = KV_PRESS;
                else if (roll < 96)
                    w.key_value = KV_REPEAT;
                else
                    w.key_value = KV_ODD;
            end
        endcase
        return w;
    endfunction

    initial
    begin
        item_t w;
        int    quota;
        int    counted;
        int    burst_left;
        int    gap;
        int    style;
        logic  kb;
        logic [REQ_CNT_W-1:0] cnt;

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        keys_ch.valid     <= 1'b0;
        keys_ch.kind      <= 1'b0;
        keys_ch.ev_type   <= '0;
        keys_ch.ev_code   <= '0;
        keys_ch.key_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset settings, no keybind loaded ----
        send_word(key_word(KIND_EVENT, EV_SYNC, 10'd0, KV_PRESS));     // non-key type, ignored
        send_word(key_word(KIND_EVENT, EV_TOP, 10'd767, KV_ODD));      // top type, ignored
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd0, KV_PRESS)); // held, never detects

        // ---- zero groups: any press or repeat matches while armed ----
        drain();
        load_chord(1'b1, '0, REQ_ALL_ONES, '0, '0, REQ_ALL_ONES);
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd767, KV_PRESS));  // detect, disarm
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd767, KV_REPEAT)); // disarmed
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd300, KV_RELEASE)); // not held, re-arms
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd767, KV_ODD));    // acts as repeat

        // ---- two groups; group 1 only takes its last alternative ----
        drain();
        load_chord(1'b1, 3'd2,
                   pack_group(10'd29, 10'd97, 10'd0, 10'd0, 4'b0011),
                   pack_group(10'd31, 10'd700, 10'd511, 10'd42, 4'b1000),
                   REQ_ALL_ONES, '0);
        send_word(key_word(KIND_DEV_ERROR, KEY_EVENT_TYPE, 10'd767, KV_PRESS)); // clear, re-arm
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd31, KV_PRESS));  // disabled alternative
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd97, KV_PRESS));  // group 1 still open
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd42, KV_PRESS));  // chord complete
        // fill the set to its depth, then press into the full set
        for (int i = 0; i < DEF_MAX_HELD - 3; i++)
            send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, code_t'(100 + i), KV_PRESS));
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd767, KV_PRESS)); // dropped
        send_word(key_word(KIND_EVENT, KEY_EVENT_TYPE, 10'd97, KV_PRESS));  // held already, kept

        // ---- random phases, each under its own chord setting ----
        quota = RANDOM_WORDS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            for (int i = 0; i < POOL_SIZE; i++)
                chord_pool[i] = code_t'($urandom_range(0, 767));
            kb = (p == 0) ? 1'b0 : ($urandom_range(0, 7) != 0);
            case (p)
                1:       cnt = 3'd7;                 // saturates to the group limit
                2:       cnt = 3'd4;
                3:       cnt = 3'd1;
                default: cnt = REQ_CNT_W'($urandom_range(0, 7));
            endcase
            load_chord(kb, cnt, random_group(), random_group(), random_group(),
                       random_group());

            counted    = 0;
            burst_left = 0;
            style      = STYLE_CHORD;
            while (counted < quota)
            begin
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0)
                    begin
                        keys_ch.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 20);
                    gap = $urandom_range(0, 99);
                    style = (gap < 65) ? STYLE_CHORD : (gap < 90) ? STYLE_FILL : STYLE_NOISE;
                end
                // sender holds off mid-phase until the pipe is empty
                if (p == 2 && counted == quota / 2)
                    drain();
                w = make_word(style);
                send_word(w);
                burst_left--;
                counted++;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_hotkey_chord_detector OK");
        else
            $display("tb_hotkey_chord_detector NOT OK");
        $finish;
    end

endmodule
